/* design/integer_field_formatter_unit_assert.svh */
// assertion macros shared by the formatter modules
`ifndef INTEGER_FIELD_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_UNIT_ASSERT_SVH

// property that must hold in the next cycle
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// property that must hold in the same cycle
`define IFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/iff_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_pkg
// types and constants of the integer field formatter
// ----------------------------------------------------------------------------
package iff_pkg;

  localparam int DigitBuffer = 32;
  localparam int MaxWidth    = 63;
  localparam int ResultCap   = 63;
  localparam int LenW        = $clog2(DigitBuffer + 1);
  localparam int BufIdxW     = $clog2(DigitBuffer);
  localparam int QueueDepth  = 2;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } base_sel_t;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        negative;
    logic [1:0]  base_select;
    logic        uppercase;
    logic        left_justify;
    logic        zero_pad;
    logic        force_plus;
    logic        space_sign;
    logic        alternate_form;
    logic        precision_given;
    logic [5:0]  precision;
    logic [5:0]  width;
  } iff_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } iff_out_t;

  // finished body from the front part, characters held least significant first
  typedef struct packed {
    logic [DigitBuffer-1:0][7:0] body;
    logic [LenW-1:0]             len;
    logic [5:0]                  width;
    logic                        left_justify;
    logic                        space_before;
  } iff_job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else c = (up ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

/* design/iff_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_front
// converts one item into its body buffer digit by digit; takes no new item while busy
// ----------------------------------------------------------------------------
`include "integer_field_formatter_unit_assert.svh"
module iff_front import iff_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  iff_in_t  item,
  output logic     busy,
  output logic     job_valid,
  output iff_job_t job,
  input  logic     job_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIGIT, S_PREC, S_ZPAD, S_PREFIX, S_SIGN, S_DONE
  } state_t;

  state_t                      state;
  logic [63:0]                 m;
  logic [63:0]                 q;
  logic [1:0]                  ph;
  logic [DigitBuffer-1:0][7:0] buf_q;
  logic [LenW-1:0]             len;
  logic [LenW-1:0]             pad_cnt;
  logic [LenW-1:0]             prec;
  logic [6:0]                  wz;
  logic [5:0]                  w;
  base_sel_t                   bsel;
  logic up, lj, zp, hs, neg, pl, sp;

  logic [3:0]  dig;
  logic [63:0] m_next;
  logic        full;
  logic [LenW-1:0] len_m1, len_m2;
  logic [63:0] dq1, dq2, dq3, dq4, dq5, dr, dq_fix;
  logic        dhi;

  // divide by ten by reciprocal shift-add, spread over the ph phases of each digit
  always_comb begin
    dq1    = (m >> 1) + (m >> 2);
    dq2    = dq1 + (dq1 >> 4);
    dq3    = q + (q >> 8);
    dq4    = dq3 + (dq3 >> 16);
    dq5    = dq4 + (dq4 >> 32);
    dr     = m - ((q << 3) + (q << 1));
    dhi    = (dr > 64'd9);
    dq_fix = q + {63'd0, dhi};
  end

  // hex, octal, binary are shifts; decimal takes the corrected quotient
  always_comb begin
    unique case (bsel)
      BASE_HEX: begin dig = m[3:0];        m_next = m >> 4; end
      BASE_OCT: begin dig = {1'b0, m[2:0]}; m_next = m >> 3; end
      BASE_BIN: begin dig = {3'd0, m[0]};  m_next = m >> 1; end
      default:  begin
        m_next = dq_fix;
        dig    = dhi ? 4'(dr - 64'd10) : 4'(dr);
      end
    endcase
  end

  assign full   = (len == LenW'(DigitBuffer));
  assign len_m1 = len - LenW'(1);
  assign len_m2 = len - LenW'(2);
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job_valid <= 1'b0;
      len       <= '0;
      ph        <= 2'd0;
      bsel      <= BASE_DEC;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            m    <= item.magnitude;
            bsel <= base_sel_t'(item.base_select);
            up   <= item.uppercase;
            lj   <= item.left_justify;
            zp   <= item.zero_pad & ~item.precision_given & ~item.left_justify;
            hs   <= item.alternate_form && item.base_select != BASE_DEC &&
                    item.magnitude != 64'd0;
            neg  <= item.negative;
            pl   <= item.force_plus;
            sp   <= item.space_sign;
            w    <= item.width;
            prec <= item.precision_given ?
                    ((item.precision > 6'(DigitBuffer)) ? LenW'(DigitBuffer)
                                                        : LenW'(item.precision))
                    : '0;
            wz   <= ({1'b0, item.width} != 7'd0 && item.zero_pad &&
                     (item.negative || item.force_plus || item.space_sign)) ?
                    {1'b0, item.width} - 7'd1 : {1'b0, item.width};
            len     <= '0;
            pad_cnt <= '0;
            ph      <= 2'd0;
            state <= (item.precision_given && item.magnitude == 64'd0) ? S_PREC
                                                                       : S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (bsel == BASE_DEC && ph == 2'd0) begin
            q  <= dq2;
            ph <= 2'd1;
          end else if (bsel == BASE_DEC && ph == 2'd1) begin
            q  <= dq5 >> 3;
            ph <= 2'd2;
          end else begin
            ph <= 2'd0;
            buf_q[BufIdxW'(len)] <= digit_char(dig, up);
            len <= len + LenW'(1);
            m   <= m_next;
            if (m_next == 64'd0 || len == LenW'(DigitBuffer - 1)) state <= S_PREC;
          end
        end
        S_PREC: begin
          if (len < prec && !full) begin
            buf_q[BufIdxW'(len)] <= 8'h30;
            len <= len + LenW'(1);
          end else state <= S_ZPAD;
        end
        S_ZPAD: begin
          if (zp && 7'(len) < wz && !full) begin
            buf_q[BufIdxW'(len)] <= 8'h30;
            len     <= len + LenW'(1);
            pad_cnt <= pad_cnt + LenW'(1);
          end else state <= hs ? S_PREFIX : S_SIGN;
        end
        S_PREFIX: begin
          // trims padded zeros, then writes prefix in one step
          logic [LenW-1:0] l;
          logic [LenW-1:0] p;
          logic            is_hb;
          l = len;
          p = pad_cnt;
          is_hb = (bsel == BASE_HEX) || (bsel == BASE_BIN);
          if (p != '0 && 7'(len) == wz) begin
            l = len_m1;
            p = p - LenW'(1);
            if (p != '0 && is_hb) l = len_m2;
          end
          if (is_hb) begin
            if (l < LenW'(DigitBuffer)) begin
              buf_q[BufIdxW'(l)] <= (bsel == BASE_BIN) ? 8'h62 : (up ? 8'h58 : 8'h78);
              if (l + LenW'(1) < LenW'(DigitBuffer)) begin
                buf_q[BufIdxW'(l + LenW'(1))] <= 8'h30;
                l = l + LenW'(2);
              end else l = l + LenW'(1);
            end
          end else if (l < LenW'(DigitBuffer) &&
                       (l == '0 || buf_q[BufIdxW'(l - LenW'(1))] != 8'h30)) begin
            buf_q[BufIdxW'(l)] <= 8'h30;
            l = l + LenW'(1);
          end
          len   <= l;
          state <= S_SIGN;
        end
        S_SIGN: begin
          if (!full && (neg || pl || sp)) begin
            buf_q[BufIdxW'(len)] <= neg ? 8'h2D : (pl ? 8'h2B : 8'h20);
            len <= len + LenW'(1);
          end
          job_valid <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (job_ready) begin
            job_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    job.body         = buf_q;
    job.len          = len;
    job.width        = (w > 6'(MaxWidth)) ? 6'(MaxWidth) : w;
    job.left_justify = lj;
    job.space_before = ~lj & ~zp;
  end

  `IFF_ASSERT_NOW(a_len_cap, 1'b1, len <= LenW'(DigitBuffer), "body length over buffer")
  `IFF_ASSERT_NOW(a_valid_done, job_valid, state == S_DONE, "job valid outside done")
  `IFF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not set busy")

endmodule

/* design/iff_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_queue
// two-entry queue of finished bodies between front and back
// ----------------------------------------------------------------------------
`include "integer_field_formatter_unit_assert.svh"
module iff_queue import iff_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  iff_job_t in_job,
  output logic     in_ready,
  output logic     out_valid,
  output iff_job_t out_job,
  input  logic     out_ready
);

  localparam int PtrW = $clog2(QueueDepth);

  iff_job_t          entry [QueueDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     count;
  logic              push, pop;

  assign in_ready  = (count != (PtrW+1)'(QueueDepth));
  assign out_valid = (count != '0);
  assign out_job   = entry[rd_ptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_job;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  `IFF_ASSERT_NOW(a_q_cap, 1'b1, count <= (PtrW+1)'(QueueDepth), "queue overflow")
  `IFF_ASSERT_NEXT(a_q_push, push && !pop, count == $past(count) + (PtrW+1)'(1),
                   "queue count missed push")
  `IFF_ASSERT_NEXT(a_q_pop, pop && !push, count == $past(count) - (PtrW+1)'(1),
                   "queue count missed pop")

endmodule

/* design/iff_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_back
// emits the padding and body characters of one job, one per cycle
// ----------------------------------------------------------------------------
`include "integer_field_formatter_unit_assert.svh"
module iff_back import iff_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  input  iff_job_t job,
  output logic     job_ready,
  output logic     strobe,
  output iff_out_t result
);

  typedef enum logic [1:0] {S_IDLE, S_PRE, S_BODY, S_POST} state_t;

  state_t           state;
  iff_job_t         cur;
  logic [5:0]       pad_left;
  logic [LenW-1:0]  idx;
  logic [5:0]       emitted;
  logic [5:0]       pad_pre, pad_post, pad_amt;

  assign pad_amt   = (7'(job.width) > 7'(job.len)) ? job.width - 6'(job.len) : 6'd0;
  assign pad_pre   = job.space_before ? pad_amt : 6'd0;
  assign pad_post  = job.left_justify ? pad_amt : 6'd0;
  assign job_ready = (state == S_IDLE);

  // phase after the current character, and whether anything remains
  logic       more;
  state_t     nxt;
  logic [5:0] pad_nx;
  logic [LenW-1:0] idx_nx;
  always_comb begin
    nxt = state; pad_nx = pad_left; idx_nx = idx;
    unique case (state)
      S_PRE:  pad_nx = pad_left - 6'd1;
      S_BODY: idx_nx = idx - LenW'(1);
      S_POST: pad_nx = pad_left - 6'd1;
      default: ;
    endcase
    if (state == S_PRE && pad_nx == 6'd0) begin
      nxt = S_BODY;
      if (idx_nx == '0) begin
        nxt = S_POST;
        pad_nx = cur.left_justify ? pad_left : 6'd0;
      end
    end
    if (state == S_BODY && idx_nx == '0) begin
      nxt = S_POST;
      pad_nx = cur.left_justify ?
               ((7'(cur.width) > 7'(cur.len)) ? cur.width - 6'(cur.len) : 6'd0) : 6'd0;
    end
    more = ((nxt == S_PRE || nxt == S_POST) && pad_nx != 6'd0) ||
           (nxt == S_BODY && idx_nx != '0);
    more = more && (emitted != 6'(ResultCap - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      strobe  <= 1'b0;
      emitted <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && (pad_pre != 6'd0 || job.len != '0 || pad_post != 6'd0)) begin
            cur     <= job;
            idx     <= job.len;
            emitted <= '0;
            if (pad_pre != 6'd0) begin
              state    <= S_PRE;
              pad_left <= pad_pre;
            end else if (job.len != '0) begin
              state    <= S_BODY;
              pad_left <= '0;
            end else begin
              state    <= S_POST;
              pad_left <= pad_post;
            end
          end
        end
        S_PRE, S_BODY, S_POST: begin
          strobe           <= 1'b1;
          result.character <= (state == S_BODY) ? cur.body[BufIdxW'(idx - LenW'(1))]
                                                : 8'h20;
          result.last      <= ~more;
          emitted          <= emitted + 6'd1;
          pad_left         <= (state == S_PRE && nxt == S_BODY) ? 6'd0 : pad_nx;
          idx              <= idx_nx;
          state            <= more ? nxt : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IFF_ASSERT_NEXT(a_emit_strobe, state != S_IDLE, strobe, "active cycle gave no character")
  `IFF_ASSERT_NOW(a_cap, 1'b1, emitted <= 6'(ResultCap), "field longer than cap")
  `IFF_ASSERT_NEXT(a_last_idle, strobe && result.last, state == S_IDLE || state == S_PRE ||
                   state == S_BODY || state == S_POST, "state lost after last")

endmodule

/* design/integer_field_formatter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter_unit
// printf-style integer field formatter, one character per cycle
// ----------------------------------------------------------------------------
// usage:
//   an item (value, sign and flags) is taken when start is high and busy low.
//   the front part converts it into a body buffer digit by digit, then adds
//   precision zeros, pad zeros, a prefix for alternate form and the sign,
//   and hands the body off. busy stays high meanwhile; the next item can be
//   taken in the cycle after the hand-off, while the queue has room. with
//   the back idle, the body then passes the queue entry and the back's state
//   register before its first character shows.
//   finished bodies wait in a two-entry queue; the back part emits the field
//   as result with strobe high, one character per cycle, last on the final
//   one, and goes idle between fields. an item that prints nothing gives no
//   strobe. a field is at most 63 characters; the next conversion runs
//   meanwhile, and a full queue holds the front in hand-off with busy high.
//   reset clears the front, the queue and the back; no item is kept.
//   the receiver cannot stall: every strobe is one accepted character.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit import iff_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  iff_in_t  item,
  output logic     busy,
  output logic     strobe,
  output iff_out_t result
);

  logic     f_valid, f_ready, b_valid, b_ready;
  iff_job_t f_job, b_job;

  iff_front u_front (
    .clk, .rst, .start, .item, .busy,
    .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  iff_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_job(f_job), .in_ready(f_ready),
    .out_valid(b_valid), .out_job(b_job), .out_ready(b_ready)
  );

  iff_back u_back (
    .clk, .rst,
    .job_valid(b_valid), .job(b_job), .job_ready(b_ready),
    .strobe, .result
  );

endmodule
